// File: rtl/kmp_pattern_search_defines.svh
// Assertion macros for the pattern search block.
`ifndef KMP_PATTERN_SEARCH_DEFINES_SVH
`define KMP_PATTERN_SEARCH_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define KMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define KMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/kmp_pkg.sv
// Shared constants and types for the pattern search block.
package kmp_pkg;

  localparam int KMP_PATTERN_DEPTH   = 64;
  localparam int KMP_SYMBOL_BITS     = 8;
  localparam int KMP_TEXT_INDEX_BITS = 16;
  localparam int KMP_SYM_FIELD_BITS  = 8;
  localparam int KMP_POS_BITS        = 16;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEXT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SYM  = 4'b0010,
    S_CMP  = 4'b0100,
    S_OUT  = 4'b1000
  } kmp_state_t;

  typedef struct packed {
    logic pat_we;
    logic fail_we;
  } kmp_wr_t;

endpackage

// File: rtl/kmp_tables.sv
// Pattern and failure-link memories with registered reads and the shared symbol compare.
module kmp_tables #(
  parameter int DEPTH  = kmp_pkg::KMP_PATTERN_DEPTH,
  parameter int SYM_W  = kmp_pkg::KMP_SYMBOL_BITS,
  parameter int ADDR_W = 6
) (
  input  logic            clk,
  input  kmp_pkg::kmp_wr_t wr,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [SYM_W-1:0]  pat_wdata,
  input  logic [ADDR_W-1:0] fail_wdata,
  input  logic [ADDR_W-1:0] pat_raddr,
  input  logic [ADDR_W-1:0] fail_raddr,
  input  logic [SYM_W-1:0]  cmp_sym,
  output logic              sym_eq,
  output logic [ADDR_W-1:0] fail_rdata
);
  import kmp_pkg::*;

  logic [SYM_W-1:0]  pat_mem  [DEPTH];
  logic [ADDR_W-1:0] fail_mem [DEPTH];
  logic [SYM_W-1:0]  pat_q_r;
  logic [ADDR_W-1:0] fail_q_r;

  always_ff @(posedge clk) begin
    if (wr.pat_we) begin
      pat_mem[waddr] <= pat_wdata;
    end
    pat_q_r <= pat_mem[pat_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.fail_we) begin
      fail_mem[waddr] <= fail_wdata;
    end
    fail_q_r <= fail_mem[fail_raddr];
  end

  assign sym_eq     = (pat_q_r == cmp_sym);
  assign fail_rdata = fail_q_r;

endmodule

// File: rtl/kmp_pattern_search.sv
// Top level of the streaming pattern search block.
//
// Input channel in_*: in_tuser selects the command (0 loads one pattern symbol,
// 1 feeds one text symbol), in_tdata carries the symbol, in_tlast marks the last
// pattern symbol or the last text symbol. Loading a symbol after a closed pattern
// starts a new pattern; the failure table is built as symbols arrive.
// Output channel out_*: one item per text, out_tuser = 1 with the zero-based start
// of the first match in out_tdata, or out_tuser = 0 and position 0 when the text
// ends without a match. Text symbols after a match give no further result.
// Steps: a text symbol goes to S_CMP, a pattern symbol to S_SYM then S_CMP, and each
// failure link followed adds a pass through S_SYM and S_CMP. The first symbol of a
// pattern, a dropped pattern symbol and a text symbol after a match or against an
// empty pattern are handled in S_IDLE. A link step is two registered memory reads
// and one pass through the single symbol comparator. A result goes through S_OUT to
// the output register. in_tready is low while an item is being worked on.
// A result waits in the output register while out_tready is low; the block keeps
// taking items until a second result is due, then holds until the first is taken.
// Reset leaves an empty closed pattern and clears the search state; the memories
// need no clearing pass since only written entries are ever read.
`include "kmp_pattern_search_defines.svh"

module kmp_pattern_search #(
  parameter int PATTERN_DEPTH   = kmp_pkg::KMP_PATTERN_DEPTH,
  parameter int SYMBOL_BITS     = kmp_pkg::KMP_SYMBOL_BITS,
  parameter int TEXT_INDEX_BITS = kmp_pkg::KMP_TEXT_INDEX_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [kmp_pkg::KMP_SYM_FIELD_BITS-1:0] in_tdata,  // [7:0] symbol
  input  logic                                 in_tuser,  // [0] command
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [kmp_pkg::KMP_POS_BITS-1:0]     out_tdata, // [15:0] position
  output logic                                 out_tuser  // [0] found
);
  import kmp_pkg::*;

  localparam int SW = (SYMBOL_BITS < KMP_SYM_FIELD_BITS) ? SYMBOL_BITS : KMP_SYM_FIELD_BITS;
  localparam int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int LW = $clog2(PATTERN_DEPTH + 1);
  localparam int PW = (TEXT_INDEX_BITS > KMP_POS_BITS) ? TEXT_INDEX_BITS : KMP_POS_BITS;
  localparam logic [TEXT_INDEX_BITS-1:0] IDX_MAX = '1;

  kmp_state_t state_r, state_nxt;
  logic [LW-1:0]              len_r, len_nxt;
  logic                       closed_r, closed_nxt;
  logic [AW-1:0]              matched_r, matched_nxt;
  logic [TEXT_INDEX_BITS-1:0] tidx_r, tidx_nxt;
  logic                       reported_r, reported_nxt;
  logic                       text_r, text_nxt;
  logic [SW-1:0]              sym_r, sym_nxt;
  logic                       last_r, last_nxt;
  logic [AW-1:0]              pos_r, pos_nxt;
  logic [AW-1:0]              k_r, k_nxt;
  logic                       res_found_r, res_found_nxt;
  logic [KMP_POS_BITS-1:0]    res_pos_r, res_pos_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_found_r, out_found_nxt;
  logic [KMP_POS_BITS-1:0]    out_pos_r, out_pos_nxt;

  kmp_wr_t       wr;
  logic          acc;
  logic [SW-1:0] in_sym;
  logic [LW-1:0] pos_now;
  logic          room;
  logic [AW-1:0] waddr, pat_raddr, fail_raddr, fail_wdata, fail_q;
  logic [LW-1:0] len_m1, knew;
  logic [AW-1:0] k_m1;
  logic          sym_eq, hit;
  logic [PW-1:0] idx_ext, start;
  logic [TEXT_INDEX_BITS-1:0] tidx_inc;

  assign in_tready  = (state_r == S_IDLE);
  assign acc        = in_tvalid && in_tready;
  assign in_sym     = in_tdata[SW-1:0];
  assign pos_now    = closed_r ? '0 : len_r;
  assign room       = (LW'(pos_now) < LW'(PATTERN_DEPTH));
  assign len_m1     = len_r - LW'(1);
  assign k_m1       = k_r - AW'(1);
  assign knew       = LW'(k_r) + LW'(sym_eq);
  assign hit        = (knew >= len_r);
  assign idx_ext    = PW'(tidx_r);
  assign start      = idx_ext + PW'(1) - PW'(len_r);
  assign tidx_inc   = (tidx_r == IDX_MAX) ? tidx_r : tidx_r + TEXT_INDEX_BITS'(1);
  assign waddr      = (state_r == S_IDLE) ? pos_now[AW-1:0] : pos_r;
  assign pat_raddr  = (state_r == S_IDLE) ? matched_r : fail_q;
  assign fail_raddr = (state_r == S_IDLE) ? len_m1[AW-1:0] : k_m1;

  kmp_tables #(
    .DEPTH  (PATTERN_DEPTH),
    .SYM_W  (SW),
    .ADDR_W (AW)
  ) u_tables (
    .clk        (clk),
    .wr         (wr),
    .waddr      (waddr),
    .pat_wdata  (in_sym),
    .fail_wdata (fail_wdata),
    .pat_raddr  (pat_raddr),
    .fail_raddr (fail_raddr),
    .cmp_sym    (sym_r),
    .sym_eq     (sym_eq),
    .fail_rdata (fail_q)
  );

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    closed_nxt    = closed_r;
    matched_nxt   = matched_r;
    tidx_nxt      = tidx_r;
    reported_nxt  = reported_r;
    text_nxt      = text_r;
    sym_nxt       = sym_r;
    last_nxt      = last_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    wr            = '0;
    fail_wdata    = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          sym_nxt  = in_sym;
          last_nxt = in_tlast;
          text_nxt = (in_tuser == CMD_TEXT);
          if (in_tuser == CMD_LOAD) begin
            if (closed_r) begin
              len_nxt      = '0;
              matched_nxt  = '0;
              tidx_nxt     = '0;
              reported_nxt = 1'b0;
            end
            closed_nxt = in_tlast;
            if (room) begin
              wr.pat_we = 1'b1;
              pos_nxt   = pos_now[AW-1:0];
              if (pos_now == '0) begin
                wr.fail_we = 1'b1;
                len_nxt    = LW'(1);
              end else begin
                state_nxt = S_SYM;
              end
            end
          end else begin
            closed_nxt = 1'b1;
            if (reported_r) begin
              if (in_tlast) begin
                matched_nxt  = '0;
                tidx_nxt     = '0;
                reported_nxt = 1'b0;
              end
            end else if (len_r == '0) begin
              res_found_nxt = 1'b1;
              res_pos_nxt   = idx_ext[KMP_POS_BITS-1:0];
              reported_nxt  = 1'b1;
              tidx_nxt      = tidx_inc;
              if (in_tlast) begin
                matched_nxt  = '0;
                tidx_nxt     = '0;
                reported_nxt = 1'b0;
              end
              state_nxt = S_OUT;
            end else begin
              k_nxt     = matched_r;
              state_nxt = S_CMP;
            end
          end
        end
      end
      S_SYM: begin
        k_nxt     = fail_q;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!sym_eq && (k_r != '0)) begin
          state_nxt = S_SYM;
        end else if (!text_r) begin
          wr.fail_we = 1'b1;
          fail_wdata = knew[AW-1:0];
          len_nxt    = LW'(pos_r) + LW'(1);
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_IDLE;
          tidx_nxt  = tidx_inc;
          if (hit) begin
            res_found_nxt = 1'b1;
            res_pos_nxt   = start[KMP_POS_BITS-1:0];
            reported_nxt  = 1'b1;
            matched_nxt   = '0;
            state_nxt     = S_OUT;
          end else begin
            matched_nxt = knew[AW-1:0];
          end
          if (last_r) begin
            if (!hit) begin
              res_found_nxt = 1'b0;
              res_pos_nxt   = '0;
              state_nxt     = S_OUT;
            end
            matched_nxt  = '0;
            tidx_nxt     = '0;
            reported_nxt = 1'b0;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pos_nxt   = res_pos_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      closed_r    <= 1'b1;
      matched_r   <= '0;
      tidx_r      <= '0;
      reported_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      closed_r    <= closed_nxt;
      matched_r   <= matched_nxt;
      tidx_r      <= tidx_nxt;
      reported_r  <= reported_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    text_r      <= text_nxt;
    sym_r       <= sym_nxt;
    last_r      <= last_nxt;
    pos_r       <= pos_nxt;
    k_r         <= k_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pos_r;
  assign out_tuser  = out_found_r;

  `KMP_ASSERT_NOW(a_reported_no_partial, reported_r, (matched_r == '0), "partial match kept after report")
  `KMP_ASSERT_NOW(a_matched_below_len, ((state_r == S_IDLE) && (len_r != '0)), (LW'(matched_r) < len_r), "matched length reached pattern length")
  `KMP_ASSERT_NOW(a_link_below_pos, ((state_r == S_CMP) && !text_r), (k_r < pos_r), "failure link not below load position")
  `KMP_ASSERT_NEXT(a_empty_pattern_hit, (acc && (in_tuser == CMD_TEXT) && !reported_r && (len_r == '0)), ((state_r == S_OUT) && res_found_r), "empty pattern gave no match")

endmodule

// File: test/kmp_pattern_search_test.sv
// Self-checking testbench for kmp_pattern_search: pattern and text streams against a KMP predictor.
`timescale 1ns / 100ps

module kmp_pattern_search_test;
  import kmp_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 1700;
  localparam int DIR_COUNT = 23;

  typedef struct packed {
    logic        found;
    logic [15:0] position;
  } search_result_t;

  typedef struct packed {
    logic           cmd;
    logic [7:0]     sym;
    logic           last;
    logic           fixed;
    search_result_t res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [KMP_SYM_FIELD_BITS-1:0] in_tdata;
  logic in_tuser;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [KMP_POS_BITS-1:0] out_tdata;
  logic out_tuser;

  // Fixed expectation travels alongside the item it belongs to.
  logic row_fixed;
  search_result_t row_res;

  bit idle_on;
  bit stall_on;
  int error_count;
  int sent_items;
  int stalled_cycles;

  search_result_t pending_results [$];
  logic [7:0] pat_copy [$];

  // Predictor state
  logic [7:0]  pat_sym [KMP_PATTERN_DEPTH];
  logic [6:0]  fail_len [KMP_PATTERN_DEPTH];
  logic [6:0]  pat_len;
  logic        pat_closed;
  logic [6:0]  match_len;
  logic [15:0] text_pos;
  logic        reported;

  stim_row_t dir_rows [DIR_COUNT] = '{
    '{CMD_TEXT, 8'h00, 1'b0, 1'b1, '{1'b1, 16'd0}},
    '{CMD_TEXT, 8'hFF, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT, 8'h5A, 1'b1, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT, 8'h7E, 1'b1, 1'b1, '{1'b1, 16'd0}},
    '{CMD_LOAD, 8'hFF, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_LOAD, 8'h00, 1'b1, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT, 8'h00, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT, 8'hFF, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT, 8'h00, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT, 8'h33, 1'b1, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT, 8'h12, 1'b1, 1'b1, '{1'b0, 16'd0}},
    '{CMD_LOAD, 8'h41, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_LOAD, 8'h41, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_LOAD, 8'h42, 1'b1, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT, 8'h41, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT, 8'h41, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT, 8'h41, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT, 8'h42, 1'b1, 1'b0, '{1'b0, 16'd0}},
    '{CMD_LOAD, 8'h80, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT, 8'h80, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT, 8'h01, 1'b1, 1'b0, '{1'b0, 16'd0}},
    '{CMD_LOAD, 8'h01, 1'b1, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT, 8'h02, 1'b1, 1'b1, '{1'b0, 16'd0}}
  };

  kmp_pattern_search dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void log_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  function automatic logic [7:0] draw_sym(input logic [7:0] base, input int span);
    if (span == 0) begin
      return 8'($urandom);
    end
    return base + 8'($urandom_range(0, span - 1));
  endfunction

  task automatic clear_search();
    match_len = '0;
    text_pos  = '0;
    reported  = 1'b0;
  endtask

  task automatic search_step(input logic cmd, input logic [7:0] sym, input logic last,
                             output bit has, output search_result_t res);
    int k;
    int start;
    has = 1'b0;
    res = '0;
    if (cmd == CMD_LOAD) begin
      if (pat_closed) begin
        pat_len    = '0;
        pat_closed = 1'b0;
        clear_search();
      end
      if (pat_len < KMP_PATTERN_DEPTH) begin
        k = 0;
        pat_sym[pat_len] = sym;
        if (pat_len > 0) begin
          k = fail_len[pat_len - 1];
          while (k > 0 && pat_sym[k] != sym) k = fail_len[k - 1];
          if (pat_sym[k] == sym) k++;
        end
        fail_len[pat_len] = 7'(k);
        pat_len = pat_len + 7'd1;
      end
      if (last) pat_closed = 1'b1;
    end else begin
      pat_closed = 1'b1;
      if (!reported) begin
        if (pat_len == 0) begin
          has = 1'b1;
          res = '{1'b1, text_pos};
          reported = 1'b1;
        end else begin
          k = match_len;
          while (k > 0 && pat_sym[k] != sym) k = fail_len[k - 1];
          if (pat_sym[k] == sym) k++;
          if (k >= pat_len) begin
            start = int'(text_pos) + 1 - int'(pat_len);
            has = 1'b1;
            res = '{1'b1, start[15:0]};
            reported = 1'b1;
            match_len = '0;
          end else begin
            match_len = 7'(k);
          end
        end
        if (text_pos != 16'hFFFF) text_pos = text_pos + 16'd1;
      end
      if (last) begin
        if (!reported) begin
          has = 1'b1;
          res = '{1'b0, 16'd0};
        end
        clear_search();
      end
    end
  endtask

  task automatic send_item(input logic cmd, input logic [7:0] sym, input logic last,
                           input logic fixed, input search_result_t res);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= sym;
    in_tlast  <= last;
    row_fixed <= fixed;
    row_res   <= res;
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  task automatic send_text(input logic [7:0] text_q [$]);
    for (int i = 0; i < text_q.size(); i++) begin
      send_item(CMD_TEXT, text_q[i], i == text_q.size() - 1, 1'b0, '0);
    end
  endtask

  task automatic load_pattern(input logic open);
    for (int i = 0; i < pat_copy.size(); i++) begin
      send_item(CMD_LOAD, pat_copy[i], (i == pat_copy.size() - 1) && !open, 1'b0, '0);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic random_round();
    logic [7:0] base;
    logic [7:0] text_q [$];
    int span;
    int kind;
    int pick;
    int plen;
    int tlen;
    base = 8'($urandom);
    span = $urandom_range(0, 4);
    kind = $urandom_range(0, 99);
    idle_on  = ($urandom_range(0, 6) != 0);
    stall_on = ($urandom_range(0, 6) != 0);
    if (kind < 85) begin
      if (kind < 60) begin
        pick = $urandom_range(0, 99);
        plen = (pick < 85) ? $urandom_range(1, 8) :
               (pick < 96) ? $urandom_range(9, 24) : $urandom_range(60, 70);
        pat_copy.delete();
        for (int i = 0; i < plen; i++) pat_copy.push_back(draw_sym(base, span));
        load_pattern($urandom_range(0, 11) == 0);
      end else if (kind < 72) begin
        // long runs force deep failure-link chains
        plen = $urandom_range(2, KMP_PATTERN_DEPTH);
        pat_copy.delete();
        for (int i = 0; i < plen - 1; i++) pat_copy.push_back(base);
        pat_copy.push_back(base + 8'd1);
        load_pattern(1'b0);
        tlen = $urandom_range(plen - 1, plen + 12);
        for (int i = 0; i < tlen; i++) begin
          pick = $urandom_range(0, 19);
          text_q.push_back(pick == 0 ? base + 8'd2 : pick == 1 ? base + 8'd1 : base);
        end
        if ($urandom_range(0, 1) == 1) text_q.push_back(base + 8'd1);
        send_text(text_q);
        return;
      end
      if (pat_copy.size() != 0 && pat_copy.size() <= 30 && $urandom_range(0, 9) < 6) begin
        tlen = $urandom_range(0, 8);
        for (int i = 0; i < tlen; i++) text_q.push_back(draw_sym(base, span));
        foreach (pat_copy[i]) text_q.push_back(pat_copy[i]);
        tlen = $urandom_range(0, 4);
        for (int i = 0; i < tlen; i++) text_q.push_back(draw_sym(base, span));
      end else begin
        tlen = $urandom_range(1, 20);
        for (int i = 0; i < tlen; i++) text_q.push_back(draw_sym(base, span));
      end
      send_text(text_q);
    end else begin
      tlen = $urandom_range(1, 6);
      for (int i = 0; i < tlen; i++) begin
        send_item(1'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin : scoreboard
    bit has;
    search_result_t want;
    search_result_t got;
    if (rst_n) begin
      stalled_cycles++;
      if (in_tvalid && in_tready) begin
        stalled_cycles = 0;
        sent_items++;
        search_step(in_tuser, in_tdata, in_tlast, has, want);
        if (row_fixed) begin
          pending_results.push_back(row_res);
        end else if (has) begin
          pending_results.push_back(want);
        end
      end
      if (out_tvalid && out_tready) begin
        stalled_cycles = 0;
        got = '{out_tuser, out_tdata};
        if (pending_results.size() == 0) begin
          log_error($sformatf("unexpected result found=%0b position=%0d",
                              got.found, got.position));
        end else begin
          want = pending_results.pop_front();
          if (got.found !== want.found || got.position !== want.position) begin
            log_error($sformatf("mismatch: expected found=%0b position=%0d, %s",
                                want.found, want.position,
                                $sformatf("got found=%0b position=%0d",
                                          got.found, got.position)));
          end
        end
      end
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : receiver
    int gap;
    out_tready <= 1'b0;
    forever begin
      gap = stall_on ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  initial begin : stimulus
    bit paused;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= CMD_LOAD;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    row_fixed <= 1'b0;
    row_res   <= '0;
    idle_on   = 1'b1;
    stall_on  = 1'b1;
    paused    = 1'b0;
    error_count    = 0;
    sent_items     = 0;
    stalled_cycles = 0;
    pat_len    = '0;
    pat_closed = 1'b1;
    clear_search();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].cmd, dir_rows[i].sym, dir_rows[i].last,
                dir_rows[i].fixed, dir_rows[i].res);
    end

    while (sent_items < RANDOM_ITEMS) begin
      random_round();
      if (!paused && sent_items >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
